### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked assertions used in the RTL of the expression
// evaluator. Each assumes signals named clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PEE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PEE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pee_pkg.sv
// ---------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ---------------------------------------------------------------------------
package pee_pkg;

    // Default depth of the operand stack.
    localparam int STACK_DEPTH_DEF = 64;

    // Operand word width.
    localparam int WORD_W = 32;

    // Width of an operand taken from a symbol byte (byte minus '0').
    localparam int LIT_W = 9;

    // Depth of the queue between front and back, a power of two.
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Symbol bytes.
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;
    localparam logic [7:0] SYM_ZERO = 8'h30;

    // Status codes, also used as the sticky error.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // Operation class of one item.
    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    // Classified item as it travels from front to back.
    typedef struct packed {
        op_t                     op;
        logic signed [LIT_W-1:0] literal;
        logic                    last;
    } item_t;

endpackage

### rtl/postfix_expression_evaluator_unit.sv
// ---------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix expression evaluator with a bounded 32-bit operand stack.
// ---------------------------------------------------------------------------
// Bytes of a postfix expression enter one item at a time; '+', '-', '*' and
// '/' pop two operands (right operand on top) and push the result, wrapping
// modulo 2^32, with division truncating toward zero; any other byte pushes
// its value minus '0'. After the item marked last, one result item carries
// the stack top and a status (0 ok, 1 underflow or empty, 2 overflow,
// 3 divide by zero; value is zero unless ok), and the stack is cleared. The
// first error is sticky until the last byte. The front accepts one item per
// cycle into a two-entry queue while it is not full; the back executes a push
// directly in its idle state, '+', '-' and '*' via a registered read of the
// stack memory, and '/' via the bit-serial divider (one quotient bit per
// cycle). The last item also passes a state that loads the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_expression_evaluator_unit
#(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         symbol,
    input  logic                               last,
    input  logic                               in_valid,
    output logic                               in_stall,
    output logic signed [pee_pkg::WORD_W-1:0]  value,
    output logic [1:0]                         status,
    output logic                               out_valid,
    input  logic                               out_stall
);

    logic           q_valid;
    logic           q_pop;
    pee_pkg::item_t q_item;
    logic           err_result;

    // Front: accept and classify.
    pee_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .symbol   (symbol),
        .last     (last),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: execute on the stack and report.
    pee_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

    // A result item that carries an error status.
    assign err_result = out_valid && (status != pee_pkg::ST_OK);

    // Checks on the internal queue and the result.
    `PEE_ASSERT_IMP(a_pop_has_data, q_pop, q_valid, "queue popped while empty")
    `PEE_ASSERT_NXT(a_pop_frees_slot, q_pop, !in_stall, "queue full right after a pop")
    `PEE_ASSERT_IMP(a_err_value_zero, err_result, value == 0, "nonzero value with error status")

endmodule

### rtl/pee_front.sv
// ---------------------------------------------------------------------------
// pee_front
// Accepts symbol bytes, classifies them into operations and literals, and
// holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
module pee_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           symbol,
    input  logic                 last,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 q_valid,
    output pee_pkg::item_t       q_item,
    input  logic                 q_pop
);

    pee_pkg::item_t                   q_mem_reg [pee_pkg::Q_DEPTH];
    logic [pee_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [pee_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [pee_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    pee_pkg::item_t                   item_in;
    logic                             push;

    // Classify the incoming byte.
    always_comb
    begin
        item_in.last    = last;
        item_in.literal = $signed({1'b0, symbol} - {1'b0, pee_pkg::SYM_ZERO});
        case (symbol)
            pee_pkg::SYM_ADD: item_in.op = pee_pkg::OP_ADD;
            pee_pkg::SYM_SUB: item_in.op = pee_pkg::OP_SUB;
            pee_pkg::SYM_MUL: item_in.op = pee_pkg::OP_MUL;
            pee_pkg::SYM_DIV: item_in.op = pee_pkg::OP_DIV;
            default:          item_in.op = pee_pkg::OP_PUSH;
        endcase
    end

    // Queue control.
    assign in_stall = (cnt_reg == pee_pkg::QCNT_W'(pee_pkg::Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + pee_pkg::QPTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + pee_pkg::QPTR_W'(1);
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + pee_pkg::QCNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - pee_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### rtl/pee_div.sv
// ---------------------------------------------------------------------------
// pee_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The divisor must be nonzero.
// ---------------------------------------------------------------------------
module pee_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pee_pkg::WORD_W-1:0]   dividend,
    input  logic [pee_pkg::WORD_W-1:0]   divisor,
    output logic                         done,
    output logic [pee_pkg::WORD_W-1:0]   quotient
);

    localparam int W     = pee_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     mb_reg, mb_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;

    // One restoring step on the magnitudes.
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, mb_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            mb_next   = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            cnt_next  = CNT_W'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    // Apply the sign of the quotient.
    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

### rtl/pee_back.sv
// ---------------------------------------------------------------------------
// pee_back
// Executes classified items on the operand stack. The top entry lives in a
// register; the entries below it live in a single-port-style memory with a
// registered read. Produces the result of each expression.
// ---------------------------------------------------------------------------
module pee_back
#(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  pee_pkg::item_t                     q_item,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pee_pkg::WORD_W-1:0]  value,
    output logic [1:0]                         status
);

    localparam int W         = pee_pkg::WORD_W;
    localparam int MEM_DEPTH = STACK_DEPTH - 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_READ = 4'b0010,
        BK_DIV  = 4'b0100,
        BK_FIN  = 4'b1000
    } bk_state_t;

    bk_state_t         state_reg, state_next;
    logic [W-1:0]      tos_reg, tos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    pee_pkg::status_t  err_reg, err_next;
    pee_pkg::op_t      op_reg, op_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      value_reg, value_next;
    pee_pkg::status_t  status_reg, status_next;

    logic [W-1:0]      stack_mem [MEM_DEPTH];
    logic [W-1:0]      rd_data_reg;
    logic              rd_en, wr_en;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    logic              div_start, div_done;
    logic [W-1:0]      div_quot;
    logic [W-1:0]      product;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign wr_addr = cnt_m1[ADDR_W-1:0];
    assign rd_addr = cnt_m2[ADDR_W-1:0];

    // Low word of the product; the result lands in the top register.
    assign product = rd_data_reg * tos_reg;

    pee_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer for one item at a time.
    always_comb
    begin
        state_next     = state_reg;
        tos_next       = tos_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;

        // The output register empties when its item is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_item.op;
                    last_next = q_item.last;
                    if (err_reg != pee_pkg::ST_OK)
                    begin
                        // A sticky error skips everything up to the last byte.
                        if (q_item.last)
                        begin
                            state_next = BK_FIN;
                        end
                    end
                    else if (q_item.op == pee_pkg::OP_PUSH)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            err_next = pee_pkg::ST_OVER;
                        end
                        else
                        begin
                            wr_en      = (count_reg != '0);
                            tos_next   = W'(q_item.literal);
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (q_item.last)
                        begin
                            state_next = BK_FIN;
                        end
                    end
                    else if (count_reg < CNT_W'(2))
                    begin
                        err_next = pee_pkg::ST_UNDER;
                        if (q_item.last)
                        begin
                            state_next = BK_FIN;
                        end
                    end
                    else
                    begin
                        // Fetch the left operand from below the top.
                        rd_en      = 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
            begin
                state_next = last_reg ? BK_FIN : BK_IDLE;
                count_next = cnt_m1;
                case (op_reg)
                    pee_pkg::OP_ADD: tos_next = rd_data_reg + tos_reg;
                    pee_pkg::OP_SUB: tos_next = rd_data_reg - tos_reg;
                    pee_pkg::OP_MUL: tos_next = product;
                    pee_pkg::OP_DIV:
                    begin
                        if (tos_reg == '0)
                        begin
                            err_next   = pee_pkg::ST_DIVZ;
                            count_next = cnt_m2;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            count_next = count_reg;
                            state_next = BK_DIV;
                        end
                    end
                    default: count_next = count_reg;
                endcase
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    tos_next   = div_quot;
                    count_next = cnt_m1;
                    state_next = last_reg ? BK_FIN : BK_IDLE;
                end
            end
            BK_FIN:
            begin
                // Report the expression once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != pee_pkg::ST_OK)
                    begin
                        status_next = err_reg;
                        value_next  = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = pee_pkg::ST_UNDER;
                        value_next  = '0;
                    end
                    else
                    begin
                        status_next = pee_pkg::ST_OK;
                        value_next  = tos_reg;
                    end
                    count_next = '0;
                    err_next   = pee_pkg::ST_OK;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            err_reg       <= pee_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Stack memory below the top entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= tos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

endmodule

### test/tb_postfix_expression_evaluator_unit.sv
// ---------------------------------------------------------------------------
// tb_postfix_expression_evaluator_unit
// Self-checking testbench of the postfix expression evaluator. Directed
// expressions cover every operator, the byte extremes and each error case.
// Random expressions follow, mostly well formed and some noise, under
// several sender and receiver idling patterns. Every result item is checked
// against a predictor that tracks its own operand stack and sticky error.
// ---------------------------------------------------------------------------
module tb_postfix_expression_evaluator_unit;

    localparam int DEPTH          = pee_pkg::STACK_DEPTH_DEF;
    localparam int WORD_W         = pee_pkg::WORD_W;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_ITEMS    = 300;

    typedef logic [7:0] sym_q_t[$];

    typedef struct {
        logic signed [WORD_W-1:0] value;
        pee_pkg::status_t         status;
    } eval_result_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic [7:0]                symbol    = '0;
    logic                      last      = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [WORD_W-1:0]  value;
    logic [1:0]                status;
    logic                      out_valid;
    logic                      out_stall = 1'b0;

    // Predictor state: its own operand stack, fill level and sticky error.
    logic signed [WORD_W-1:0]  pred_stack [DEPTH];
    int unsigned               pred_count = 0;
    pee_pkg::status_t          pred_error = pee_pkg::ST_OK;
    eval_result_t              pending_results [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int items_sent      = 0;
    int expressions     = 0;
    int results_checked = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int idle_cycles     = 0;

    postfix_expression_evaluator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (symbol),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mismatch reporting.
    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic is_operator(input logic [7:0] sym);
        return sym inside {pee_pkg::SYM_ADD, pee_pkg::SYM_SUB,
                           pee_pkg::SYM_MUL, pee_pkg::SYM_DIV};
    endfunction

    // Byte that pushes the given operand value.
    function automatic logic [7:0] lit(input int v);
        return 8'(v) + pee_pkg::SYM_ZERO;
    endfunction

    // Expected behavior of one accepted byte; queues a result on the last one.
    function automatic void predict_symbol(input logic [7:0] sym, input logic lst);
        logic signed [WORD_W-1:0] lhs;
        logic signed [WORD_W-1:0] rhs;
        logic signed [WORD_W:0]   quot;
        eval_result_t             res;
        if (pred_error == pee_pkg::ST_OK)
        begin
            if (is_operator(sym))
            begin
                if (pred_count < 2)
                begin
                    pred_error = pee_pkg::ST_UNDER;
                end
                else
                begin
                    rhs = pred_stack[pred_count - 1];
                    lhs = pred_stack[pred_count - 2];
                    pred_count -= 2;
                    case (sym)
                        pee_pkg::SYM_ADD: pred_stack[pred_count] = lhs + rhs;
                        pee_pkg::SYM_SUB: pred_stack[pred_count] = lhs - rhs;
                        pee_pkg::SYM_MUL: pred_stack[pred_count] = lhs * rhs;
                        default:
                        begin
                            // One extra bit keeps the most negative over minus one exact.
                            quot = $signed({lhs[WORD_W-1], lhs}) /
                                   $signed({rhs[WORD_W-1], rhs});
                            pred_stack[pred_count] = quot[WORD_W-1:0];
                        end
                    endcase
                    if (sym == pee_pkg::SYM_DIV && rhs == 0)
                        pred_error = pee_pkg::ST_DIVZ;
                    else
                        pred_count++;
                end
            end
            else if (pred_count >= DEPTH)
            begin
                pred_error = pee_pkg::ST_OVER;
            end
            else
            begin
                pred_stack[pred_count] = WORD_W'(int'(sym) - int'(pee_pkg::SYM_ZERO));
                pred_count++;
            end
        end
        if (lst)
        begin
            res.value  = '0;
            res.status = pred_error;
            if (pred_error == pee_pkg::ST_OK)
            begin
                if (pred_count == 0)
                    res.status = pee_pkg::ST_UNDER;
                else
                    res.value = pred_stack[pred_count - 1];
            end
            pending_results = {pending_results, res};
            pred_count = 0;
            pred_error = pee_pkg::ST_OK;
        end
    endfunction

    // Sends one item; called and returning at a falling edge.
    task automatic send_item(input logic [7:0] sym, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        last     <= lst;
        do
            @(posedge clk);
        while (in_stall);
        predict_symbol(sym, lst);
        items_sent++;
        if (lst)
            expressions++;
        @(negedge clk);
    endtask

    // Sends a whole expression, marking its final byte as last.
    task automatic send_expr(input sym_q_t seq);
        for (int i = 0; i < seq.size(); i++)
            send_item(seq[i], i == seq.size() - 1);
    endtask

    function automatic logic [7:0] rand_operand();
        logic [7:0] sym;
        if ($urandom_range(0, 3) != 0)
            return lit($urandom_range(0, 9));
        do
            sym = 8'($urandom_range(0, 255));
        while (is_operator(sym));
        return sym;
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 3))
            0:       return pee_pkg::SYM_ADD;
            1:       return pee_pkg::SYM_SUB;
            2:       return pee_pkg::SYM_MUL;
            default: return pee_pkg::SYM_DIV;
        endcase
    endfunction

    // Each operator, division with both signs, and the lowest and highest byte as operands.
    task automatic test_operators();
        sym_q_t seq;
        seq = '{lit(3), lit(4), pee_pkg::SYM_ADD};
        send_expr(seq);
        seq = '{lit(2), lit(9), pee_pkg::SYM_SUB};
        send_expr(seq);
        seq = '{8'h00, 8'hFF, pee_pkg::SYM_MUL};
        send_expr(seq);
        seq = '{lit(-7), lit(2), pee_pkg::SYM_DIV};
        send_expr(seq);
        seq = '{lit(7), lit(-2), pee_pkg::SYM_DIV};
        send_expr(seq);
        seq = '{lit(5)};
        send_expr(seq);
    endtask

    // Underflow, divide by zero, the sticky first error and a wrapping quotient.
    task automatic test_error_cases();
        sym_q_t seq;
        seq = '{pee_pkg::SYM_MUL};
        send_expr(seq);
        seq = '{lit(5), pee_pkg::SYM_ADD, lit(3)};
        send_expr(seq);
        seq = '{lit(4), lit(0), pee_pkg::SYM_DIV, pee_pkg::SYM_ADD, lit(1)};
        send_expr(seq);
        // Build 2^31 by wrapping products, then divide by minus one.
        seq = '{lit(128), lit(128), pee_pkg::SYM_MUL, lit(128), pee_pkg::SYM_MUL,
                lit(128), pee_pkg::SYM_MUL, lit(8), pee_pkg::SYM_MUL,
                lit(0), lit(1), pee_pkg::SYM_SUB, pee_pkg::SYM_DIV};
        send_expr(seq);
    endtask

    // A completely full stack, then one push too many.
    task automatic test_stack_depth();
        sym_q_t seq;
        seq = {};
        for (int i = 0; i < DEPTH; i++)
            seq = {seq, lit(1)};
        for (int i = 1; i < DEPTH; i++)
            seq = {seq, pee_pkg::SYM_ADD};
        send_expr(seq);
        seq = {};
        for (int i = 0; i <= DEPTH; i++)
            seq = {seq, lit(2)};
        seq = {seq, pee_pkg::SYM_ADD};
        send_expr(seq);
    endtask

    // Random expressions: mostly well formed, a few deep, some noise.
    task automatic test_random_expressions(input int n_items, input int idle_pct,
                                           input int stall_pct);
        sym_q_t seq;
        int     stop_at;
        int     roll;
        int     len;
        int     depth;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            seq  = {};
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                // Near or past the stack depth.
                len = $urandom_range(DEPTH - 4, DEPTH + 2);
                for (int i = 0; i < len; i++)
                    seq = {seq, rand_operand()};
                for (int i = 1; i < len; i++)
                    seq = {seq, rand_operator()};
            end
            else if (roll < 80)
            begin
                len   = $urandom_range(1, 12);
                depth = 0;
                for (int i = 0; i < len; i++)
                begin
                    if (depth < 2 || $urandom_range(0, 2) == 0)
                    begin
                        seq = {seq, rand_operand()};
                        depth++;
                    end
                    else
                    begin
                        seq = {seq, rand_operator()};
                        depth--;
                    end
                end
                while (depth > 1)
                begin
                    seq = {seq, rand_operator()};
                    depth--;
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    seq = {seq, 8'($urandom_range(0, 255))};
            end
            send_expr(seq);
        end
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    // Result checking against the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        eval_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result value %0d status %0d with none pending",
                                       value, status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                    report_error($sformatf("value %0d, predicted %0d", value, want.value));
                if (status !== want.status)
                    report_error($sformatf("status %0d, predicted %s", status,
                                           want.status.name()));
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no item moved in %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_operators();
        test_error_cases();
        test_stack_depth();
        test_random_expressions(PHASE_ITEMS, 0, 0);
        test_random_expressions(PHASE_ITEMS, 80, 0);
        test_random_expressions(PHASE_ITEMS, 0, 80);
        test_random_expressions(PHASE_ITEMS, 12, 12);

        in_valid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items in %0d expressions; %0d results checked.",
                 items_sent, expressions, results_checked);
        $display("Statuses: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
                 status_seen[pee_pkg::ST_OK], status_seen[pee_pkg::ST_UNDER],
                 status_seen[pee_pkg::ST_OVER], status_seen[pee_pkg::ST_DIVZ]);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
